>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, disabled while in reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> hw/rtl/dasd_pkg.sv
package dasd_pkg;

    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int OFF_W  = 23;
    localparam int SER_W  = 22;
    localparam int SUM_W  = 25;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [MON_W-1:0]  MONTH_JAN = 4'd1;
    localparam logic [MON_W-1:0]  MONTH_FEB = 4'd2;
    localparam logic [MON_W-1:0]  MONTH_DEC = 4'd12;

    localparam logic [SER_W-1:0] DAYS_400   = 22'd146097;
    localparam logic [SER_W-1:0] DAYS_100   = 22'd36524;
    localparam logic [SER_W-1:0] DAYS_4     = 22'd1461;
    localparam logic [SER_W-1:0] DAYS_1     = 22'd365;
    // serial of 9999-12-31, counting 0001-01-01 as zero
    localparam logic [SER_W-1:0] SERIAL_MAX = 22'd3652058;

    // x / 25 == (x * 5243) >> 17 for x below 2500
    localparam logic [12:0] RECIP_25    = 13'd5243;
    localparam int          RECIP_SHIFT = 17;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DIV,
        CMD_BASE,
        CMD_SUM,
        CMD_CLAMP,
        CMD_STEP400,
        CMD_STEP100,
        CMD_STEP4,
        CMD_STEP1,
        CMD_MONTH,
        CMD_FINISH
    } dp_cmd_t;

    typedef struct packed {
        logic step_ok;
    } dp_stat_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the months ahead of m, common year
    function automatic logic [8:0] days_before(input logic [MON_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

>>> hw/rtl/dasd_ctrl.sv
`include "assert_macros.svh"

module dasd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output dasd_pkg::dp_cmd_t cmd,
    input  dasd_pkg::dp_stat_t stat
);
    import dasd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_BASE,
        S_SUM,
        S_CLAMP,
        S_Q400,
        S_Q100,
        S_Q4,
        S_Q1,
        S_MON,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = CMD_LOAD;
                    busy_next  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd        = CMD_DIV;
                state_next = S_BASE;
            end
            S_BASE:
            begin
                cmd        = CMD_BASE;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd        = CMD_SUM;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd        = CMD_CLAMP;
                state_next = S_Q400;
            end
            // each step state subtracts once per cycle until it no longer fits or reaches its cap
            S_Q400:
            begin
                cmd = CMD_STEP400;
                if (!stat.step_ok)
                    state_next = S_Q100;
            end
            S_Q100:
            begin
                cmd = CMD_STEP100;
                if (!stat.step_ok)
                    state_next = S_Q4;
            end
            S_Q4:
            begin
                cmd = CMD_STEP4;
                if (!stat.step_ok)
                    state_next = S_Q1;
            end
            S_Q1:
            begin
                cmd = CMD_STEP1;
                if (!stat.step_ok)
                    state_next = S_MON;
            end
            S_MON:
            begin
                cmd = CMD_MONTH;
                if (!stat.step_ok)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd        = CMD_FINISH;
                busy_next  = 1'b0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    `ASSERT_CLK(a_done_single, clk, rst_n, done |=> !done, "done longer than one cycle")
    `ASSERT_CLK(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accept without busy")
    `ASSERT_CLK(a_busy_drop_done, clk, rst_n, $fell(busy) |-> done, "busy fell without done")
    `ASSERT_NEVER(a_idle_busy, clk, rst_n, (state_reg == S_IDLE) && busy, "busy in idle")

endmodule

>>> hw/rtl/dasd_datapath.sv
module dasd_datapath (
    input  logic                              clk,
    input  dasd_pkg::dp_cmd_t                 cmd,
    output dasd_pkg::dp_stat_t                stat,
    input  logic [dasd_pkg::YEAR_W-1:0]       start_year,
    input  logic [dasd_pkg::MON_W-1:0]        start_month,
    input  logic [dasd_pkg::DAY_W-1:0]        start_day,
    input  logic signed [dasd_pkg::OFF_W-1:0] day_offset,
    output logic [dasd_pkg::YEAR_W-1:0]       result_year,
    output logic [dasd_pkg::MON_W-1:0]        result_month,
    output logic [dasd_pkg::DAY_W-1:0]        result_day,
    output logic                              out_of_range
);
    import dasd_pkg::*;

    localparam logic [1:0] Q_CAP   = 2'd3;
    localparam logic [4:0] Q4_LAST = 5'd24;

    logic [YEAR_W-1:0]       p_reg;
    logic [MON_W-1:0]        mon_reg;
    logic [DAY_W-1:0]        day_reg;
    logic signed [OFF_W-1:0] off_reg;
    logic [6:0]              b_reg;
    logic [4:0]              c_reg;
    logic                    leap_reg;
    logic [SER_W-1:0]        base_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SER_W-1:0]        rem_reg;
    logic                    flag_reg;
    logic [YEAR_W-1:0]       year_reg;
    logic [1:0]              q100_reg;
    logic [4:0]              q4_reg;
    logic [1:0]              q1_reg;
    logic [YEAR_W-1:0]       res_year_reg;
    logic [MON_W-1:0]        res_month_reg;
    logic [DAY_W-1:0]        res_day_reg;
    logic                    res_flag_reg;

    logic [YEAR_W-1:0] y_clamp;
    logic [MON_W-1:0]  m_clamp;
    logic [11:0]       quarter;
    logic [9:0]        sixteenth;
    logic [SUM_W-1:0]  prod_b;
    logic [SUM_W-1:0]  prod_c;
    logic [11:0]       rem100;
    logic [9:0]        rem400;
    logic              leap_in;
    logic [DAY_W-1:0]  mlen_in;
    logic [DAY_W-1:0]  day_clamp;
    logic [SER_W:0]    base_calc;
    logic [SUM_W-1:0]  sum_calc;
    logic              sum_neg;
    logic              sum_over;
    logic              leap_res;
    logic [DAY_W-1:0]  mlen_res;
    logic [SER_W-1:0]  unit;
    logic [YEAR_W-1:0] year_inc;
    logic              step_ok;

    always_comb
    begin
        if (start_year < YEAR_MIN)
            y_clamp = YEAR_MIN;
        else if (start_year > YEAR_MAX)
            y_clamp = YEAR_MAX;
        else
            y_clamp = start_year;

        if (start_month < MONTH_JAN)
            m_clamp = MONTH_JAN;
        else if (start_month > MONTH_DEC)
            m_clamp = MONTH_DEC;
        else
            m_clamp = start_month;
    end

    // p = year - 1; quarter = p/4, b = p/100, c = p/400
    assign quarter   = p_reg[YEAR_W-1:2];
    assign sixteenth = p_reg[YEAR_W-1:4];
    assign prod_b    = SUM_W'(quarter) * SUM_W'(RECIP_25);
    assign prod_c    = SUM_W'(sixteenth) * SUM_W'(RECIP_25);

    // leap test on year = p + 1 from the residues of p
    assign rem100  = quarter - 12'(b_reg) * 12'd25;
    assign rem400  = sixteenth - 10'(c_reg) * 10'd25;
    assign leap_in = (p_reg[1:0] == 2'b11)
                     && (!(rem100 == 12'd24) || ((p_reg[3:0] == 4'hF) && (rem400 == 10'd24)));
    assign mlen_in = month_len(mon_reg, leap_in);

    always_comb
    begin
        if (day_reg == '0)
            day_clamp = DAY_W'(1);
        else if (day_reg > mlen_in)
            day_clamp = mlen_in;
        else
            day_clamp = day_reg;
    end

    assign base_calc = (SER_W+1)'(p_reg) * (SER_W+1)'(DAYS_1) + (SER_W+1)'(quarter)
                       - (SER_W+1)'(b_reg) + (SER_W+1)'(c_reg);

    assign sum_calc = SUM_W'(base_reg) + SUM_W'(days_before(mon_reg))
                      + SUM_W'(leap_reg && (mon_reg > MONTH_FEB))
                      + SUM_W'(day_reg) - SUM_W'(1) + SUM_W'(off_reg);

    assign sum_neg  = sum_reg[SUM_W-1];
    assign sum_over = !sum_neg && (sum_reg[SUM_W-2:0] > (SUM_W-1)'(SERIAL_MAX));

    // leap of the year being built: last year of a 4-year block, not a plain century
    assign leap_res = (q1_reg == Q_CAP) && ((q4_reg != Q4_LAST) || (q100_reg == Q_CAP));
    assign mlen_res = month_len(mon_reg, leap_res);

    always_comb
    begin
        unit     = '0;
        year_inc = '0;
        step_ok  = 1'b0;
        case (cmd)
            CMD_STEP400:
            begin
                unit     = DAYS_400;
                year_inc = YEAR_W'(400);
                step_ok  = rem_reg >= unit;
            end
            CMD_STEP100:
            begin
                unit     = DAYS_100;
                year_inc = YEAR_W'(100);
                step_ok  = (rem_reg >= unit) && (q100_reg != Q_CAP);
            end
            CMD_STEP4:
            begin
                unit     = DAYS_4;
                year_inc = YEAR_W'(4);
                step_ok  = rem_reg >= unit;
            end
            CMD_STEP1:
            begin
                unit     = DAYS_1;
                year_inc = YEAR_W'(1);
                step_ok  = (rem_reg >= unit) && (q1_reg != Q_CAP);
            end
            CMD_MONTH:
            begin
                unit    = SER_W'(mlen_res);
                step_ok = (mon_reg < MONTH_DEC) && (rem_reg >= unit);
            end
            default:
            begin
                unit    = '0;
                step_ok = 1'b0;
            end
        endcase
    end

    assign stat.step_ok = step_ok;

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                p_reg   <= y_clamp - YEAR_MIN;
                mon_reg <= m_clamp;
                day_reg <= start_day;
                off_reg <= day_offset;
            end
            CMD_DIV:
            begin
                b_reg <= prod_b[RECIP_SHIFT+6:RECIP_SHIFT];
                c_reg <= prod_c[RECIP_SHIFT+4:RECIP_SHIFT];
            end
            CMD_BASE:
            begin
                base_reg <= base_calc[SER_W-1:0];
                leap_reg <= leap_in;
                day_reg  <= day_clamp;
            end
            CMD_SUM:
                sum_reg <= $signed(sum_calc);
            CMD_CLAMP:
            begin
                if (sum_neg)
                    rem_reg <= '0;
                else if (sum_over)
                    rem_reg <= SERIAL_MAX;
                else
                    rem_reg <= sum_reg[SER_W-1:0];
                flag_reg <= sum_neg || sum_over;
                year_reg <= YEAR_MIN;
                mon_reg  <= MONTH_JAN;
                q100_reg <= '0;
                q4_reg   <= '0;
                q1_reg   <= '0;
            end
            CMD_STEP400, CMD_STEP100, CMD_STEP4, CMD_STEP1, CMD_MONTH:
            begin
                if (step_ok)
                begin
                    rem_reg  <= rem_reg - unit;
                    year_reg <= year_reg + year_inc;
                    if (cmd == CMD_STEP100)
                        q100_reg <= q100_reg + 2'd1;
                    if (cmd == CMD_STEP4)
                        q4_reg <= q4_reg + 5'd1;
                    if (cmd == CMD_STEP1)
                        q1_reg <= q1_reg + 2'd1;
                    if (cmd == CMD_MONTH)
                        mon_reg <= mon_reg + MON_W'(1);
                end
            end
            CMD_FINISH:
            begin
                res_year_reg  <= year_reg;
                res_month_reg <= mon_reg;
                res_day_reg   <= rem_reg[DAY_W-1:0] + DAY_W'(1);
                res_flag_reg  <= flag_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign result_year  = res_year_reg;
    assign result_month = res_month_reg;
    assign result_day   = res_day_reg;
    assign out_of_range = res_flag_reg;

endmodule

>>> hw/rtl/date_add_signed_days.sv
// Gregorian date plus signed day offset, one word per start, result on done.
// A shared compare-and-subtract unit steps 400-year, 100-year, 4-year,
// year and month spans one per cycle. busy is low in the done cycle, and a
// new word is taken only once the last is done. done shows for one cycle,
// no stall; the results hold until the next word finishes.
// Reset (rst_n low, asynchronous) returns the controller to idle, no result.
module date_add_signed_days (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    output logic                              done,
    input  logic [dasd_pkg::YEAR_W-1:0]       start_year,
    input  logic [dasd_pkg::MON_W-1:0]        start_month,
    input  logic [dasd_pkg::DAY_W-1:0]        start_day,
    input  logic signed [dasd_pkg::OFF_W-1:0] day_offset,
    output logic [dasd_pkg::YEAR_W-1:0]       result_year,
    output logic [dasd_pkg::MON_W-1:0]        result_month,
    output logic [dasd_pkg::DAY_W-1:0]        result_day,
    output logic                              out_of_range
);
    import dasd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dasd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    dasd_datapath u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .stat         (stat),
        .start_year   (start_year),
        .start_month  (start_month),
        .start_day    (start_day),
        .day_offset   (day_offset),
        .result_year  (result_year),
        .result_month (result_month),
        .result_day   (result_day),
        .out_of_range (out_of_range)
    );

endmodule
